// ===== src/gpbd_pkg.sv =====
// Shared constants, types and helpers for the gate peak and base detector.
package gpbd_pkg;

   localparam int MAX_SAMPLES = 4096;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam int GATE_W = 12;
   localparam int POS_W = 12;
   localparam int AMP_W = 8;
   localparam int COEF_W = 24;
   localparam int OUT_W = 28;
   localparam int FRAC_DROP = 8;
   localparam int PROD_W = IDX_W + COEF_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W = 3;
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GATE_START   = 3'd0,
      CSR_GATE_END     = 3'd1,
      CSR_DISTANCE     = 3'd2,
      CSR_DEPTH        = 3'd3,
      CSR_SURFACE      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GATE_W-1:0] gate_start;
      logic [GATE_W-1:0] gate_end;
   } gate_cfg_type;

   typedef struct packed {
      logic [COEF_W-1:0] distance;
      logic [COEF_W-1:0] depth;
      logic [COEF_W-1:0] surface;
   } coef_cfg_type;

   typedef struct packed {
      logic [AMP_W-1:0] peak_height;
      logic             peak_found;
      logic [POS_W-1:0] peak_position;
      logic             base_found;
      logic [IDX_W-1:0] base_index;
      logic             overflow;
   } summary_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [OUT_W-1:0] sat_scale(input logic [PROD_W-1:0] prod);
      logic [PROD_W-1:0] shifted;
      shifted = prod >> FRAC_DROP;
      if (64'(shifted) > 64'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return OUT_W'(shifted);
   endfunction

endpackage

// ===== src/gpbd_front.sv =====
// Sample front end: tracks gated peak and latest zero, emits one summary per frame.
module gpbd_front
   import gpbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [AMP_W-1:0] req_amplitude,
   input  logic             req_last_sample,
   input  gate_cfg_type     gate_cfg,
   input  logic             queue_full,
   output logic             push,
   output summary_type      push_data
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [AMP_W-1:0] best_amp_ff, best_amp_in;
   logic [IDX_W-1:0] best_pos_ff, best_pos_in;
   logic             best_valid_ff, best_valid_in;
   logic [IDX_W-1:0] zero_pos_ff, zero_pos_in;
   logic             zero_valid_ff, zero_valid_in;
   logic [IDX_W-1:0] cap_pos_ff, cap_pos_in;
   logic             cap_valid_ff, cap_valid_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] idx;
   logic             gated;
   logic             accept;
   logic             base;

   assign req_stall = queue_full;
   assign accept = req_valid && !req_stall;
   assign idx = count_ff[IDX_W-1:0];
   assign gated = (32'(idx) >= 32'(gate_cfg.gate_start)) &&
                  (32'(idx) <= 32'(gate_cfg.gate_end));

   always_comb begin
      count_in = count_ff;
      best_amp_in = best_amp_ff;
      best_pos_in = best_pos_ff;
      best_valid_in = best_valid_ff;
      zero_pos_in = zero_pos_ff;
      zero_valid_in = zero_valid_ff;
      cap_pos_in = cap_pos_ff;
      cap_valid_in = cap_valid_ff;
      ovf_in = ovf_ff;
      if (count_ff >= CNT_W'(MAX_SAMPLES)) begin
         ovf_in = 1'b1;
      end else begin
         if (gated && (req_amplitude > best_amp_ff)) begin
            best_amp_in = req_amplitude;
            best_pos_in = idx;
            best_valid_in = 1'b1;
            cap_pos_in = zero_pos_ff;
            cap_valid_in = zero_valid_ff;
         end
         if (req_amplitude == '0) begin
            zero_pos_in = idx;
            zero_valid_in = 1'b1;
         end
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      base = best_valid_in && cap_valid_in;
      push = accept && req_last_sample;
      push_data.peak_height = best_valid_in ? best_amp_in : '0;
      push_data.peak_found = best_valid_in;
      push_data.peak_position = best_valid_in ? POS_W'(best_pos_in) : '0;
      push_data.base_found = base;
      push_data.base_index = base ? cap_pos_in : '0;
      push_data.overflow = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         count_ff <= '0;
         best_amp_ff <= '0;
         best_pos_ff <= '0;
         best_valid_ff <= 1'b0;
         zero_pos_ff <= '0;
         zero_valid_ff <= 1'b0;
         cap_pos_ff <= '0;
         cap_valid_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         best_amp_ff <= best_amp_in;
         best_pos_ff <= best_pos_in;
         best_valid_ff <= best_valid_in;
         zero_pos_ff <= zero_pos_in;
         zero_valid_ff <= zero_valid_in;
         cap_pos_ff <= cap_pos_in;
         cap_valid_ff <= cap_valid_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

// ===== src/gpbd_queue.sv =====
// Short summary queue between the front end and the scaling back end.
module gpbd_queue
   import gpbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  summary_type      push_data,
   input  logic             pop,
   output summary_type      pop_data,
   output queue_status_type status
);

   summary_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push;
   logic              do_pop;

   assign status.full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] ptr);
      return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== src/gpbd_back.sv =====
// Back end: scales the base index by the three coefficients and drives the result.
module gpbd_back
   import gpbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  coef_cfg_type      coef_cfg,
   input  queue_status_type  q_status,
   input  summary_type       q_data,
   output logic              pop,
   output logic              stage_valid,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [AMP_W-1:0]  rsp_peak_height,
   output logic              rsp_peak_found,
   output logic [POS_W-1:0]  rsp_peak_position,
   output logic              rsp_base_found,
   output logic [POS_W-1:0]  rsp_base_position,
   output logic [OUT_W-1:0]  rsp_base_distance,
   output logic [OUT_W-1:0]  rsp_depth,
   output logic [OUT_W-1:0]  rsp_surface_distance,
   output logic              rsp_frame_overflow
);

   logic               s1_valid_ff;
   summary_type        s1_sum_ff;
   logic [PROD_W-1:0]  dist_prod_ff, dist_prod_in;
   logic [PROD_W-1:0]  depth_prod_ff, depth_prod_in;
   logic [PROD_W-1:0]  surf_prod_ff, surf_prod_in;
   logic               out_valid_ff;
   logic               advance;
   logic               load_s1;

   assign advance = !out_valid_ff || !rsp_stall;
   assign load_s1 = !s1_valid_ff || advance;
   assign pop = load_s1 && !q_status.empty;
   assign stage_valid = s1_valid_ff;
   assign rsp_valid = out_valid_ff;

   assign dist_prod_in = PROD_W'(q_data.base_index) * PROD_W'(coef_cfg.distance);
   assign depth_prod_in = PROD_W'(q_data.base_index) * PROD_W'(coef_cfg.depth);
   assign surf_prod_in = PROD_W'(q_data.base_index) * PROD_W'(coef_cfg.surface);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_s1) begin
            s1_valid_ff <= !q_status.empty;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_sum_ff <= q_data;
         dist_prod_ff <= dist_prod_in;
         depth_prod_ff <= depth_prod_in;
         surf_prod_ff <= surf_prod_in;
      end
      if (advance && s1_valid_ff) begin
         rsp_peak_height <= s1_sum_ff.peak_height;
         rsp_peak_found <= s1_sum_ff.peak_found;
         rsp_peak_position <= s1_sum_ff.peak_position;
         rsp_base_found <= s1_sum_ff.base_found;
         rsp_base_position <= POS_W'(s1_sum_ff.base_index);
         rsp_base_distance <= sat_scale(dist_prod_ff);
         rsp_depth <= sat_scale(depth_prod_ff);
         rsp_surface_distance <= sat_scale(surf_prod_ff);
         rsp_frame_overflow <= s1_sum_ff.overflow;
      end
   end

endmodule

// ===== src/gate_peak_base_detector_unit.sv =====
// Top level of the gate peak and base detector: registers, front end, queue, back end.
//
// Usage:
//   req_* carries one amplitude sample per transfer; req_last_sample marks the
//   final sample of a frame. Samples are indexed from 0 within each frame.
//   rsp_* carries one result per frame, produced by the transfer that carries
//   req_last_sample. csr_* writes the gate bounds and the three Q8.16
//   coefficients; csr_ready is always high. Write them only while idle.
// Throughput: one sample per cycle while req_stall is low; the front end updates its
//   peak and zero trackers with one compare pair per sample.
// Path: the summary of the last-sample transfer is registered in the summary
//   queue, then in the multiplier stage, then in the output register.
// Stall: while rsp_stall is high the result holds; the back end fills, then
//   the two-entry summary queue, and only then is req_stall raised.
// Reset: synchronous; clears frame state, queue and result valid, and loads
//   the default gate (0..4095) and coefficients (1.0, 1.0, 0.0).
module gate_peak_base_detector_unit
   import gpbd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [AMP_W-1:0]     req_amplitude,
   input  logic                 req_last_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [AMP_W-1:0]     rsp_peak_height,
   output logic                 rsp_peak_found,
   output logic [POS_W-1:0]     rsp_peak_position,
   output logic                 rsp_base_found,
   output logic [POS_W-1:0]     rsp_base_position,
   output logic [OUT_W-1:0]     rsp_base_distance,
   output logic [OUT_W-1:0]     rsp_depth,
   output logic [OUT_W-1:0]     rsp_surface_distance,
   output logic                 rsp_frame_overflow,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_data
);

   gate_cfg_type     gate_cfg_ff;
   coef_cfg_type     coef_cfg_ff;
   logic             push;
   summary_type      push_data;
   logic             pop;
   summary_type      pop_data;
   queue_status_type q_status;
   logic             stage_valid;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_cfg_ff.gate_start <= '0;
         gate_cfg_ff.gate_end <= '1;
         coef_cfg_ff.distance <= COEF_W'(65536);
         coef_cfg_ff.depth <= COEF_W'(65536);
         coef_cfg_ff.surface <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GATE_START: gate_cfg_ff.gate_start <= csr_data[GATE_W-1:0];
            CSR_GATE_END:   gate_cfg_ff.gate_end <= csr_data[GATE_W-1:0];
            CSR_DISTANCE:   coef_cfg_ff.distance <= csr_data;
            CSR_DEPTH:      coef_cfg_ff.depth <= csr_data;
            CSR_SURFACE:    coef_cfg_ff.surface <= csr_data;
            default:        ;
         endcase
      end
   end

   gpbd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_amplitude   (req_amplitude),
      .req_last_sample (req_last_sample),
      .gate_cfg        (gate_cfg_ff),
      .queue_full      (q_status.full),
      .push            (push),
      .push_data       (push_data)
   );

   gpbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   gpbd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .coef_cfg             (coef_cfg_ff),
      .q_status             (q_status),
      .q_data               (pop_data),
      .pop                  (pop),
      .stage_valid          (stage_valid),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_peak_height      (rsp_peak_height),
      .rsp_peak_found       (rsp_peak_found),
      .rsp_peak_position    (rsp_peak_position),
      .rsp_base_found       (rsp_base_found),
      .rsp_base_position    (rsp_base_position),
      .rsp_base_distance    (rsp_base_distance),
      .rsp_depth            (rsp_depth),
      .rsp_surface_distance (rsp_surface_distance),
      .rsp_frame_overflow   (rsp_frame_overflow)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("summary pushed into a full queue");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (q_status.full && stage_valid && rsp_valid))
      else $error("input stalled while the back end had room");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(stage_valid))
      else $error("result appeared without a filled multiplier stage");
`endif

endmodule

// ===== tb/gate_result_checker.sv =====
// Checker for the gate peak and base detector: tracks each frame, predicts its result, compares.
module gate_result_checker
   import gpbd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [AMP_W-1:0]     req_amplitude,
   input  logic                 req_last_sample,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [AMP_W-1:0]     rsp_peak_height,
   input  logic                 rsp_peak_found,
   input  logic [POS_W-1:0]     rsp_peak_position,
   input  logic                 rsp_base_found,
   input  logic [POS_W-1:0]     rsp_base_position,
   input  logic [OUT_W-1:0]     rsp_base_distance,
   input  logic [OUT_W-1:0]     rsp_depth,
   input  logic [OUT_W-1:0]     rsp_surface_distance,
   input  logic                 rsp_frame_overflow,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_data,
   output int                   failures,
   output int                   outstanding,
   output int                   frames_checked,
   output int                   base_frames,
   output int                   long_frames
);

   localparam longint unsigned SCALE_LIMIT = (64'd1 << OUT_W) - 1;

   typedef struct packed {
      logic [AMP_W-1:0] peak_height;
      logic             peak_found;
      logic [POS_W-1:0] peak_position;
      logic             base_found;
      logic [POS_W-1:0] base_position;
      logic [OUT_W-1:0] base_distance;
      logic [OUT_W-1:0] depth;
      logic [OUT_W-1:0] surface_distance;
      logic             frame_overflow;
   } frame_result_type;

   frame_result_type expected_frames[$];

   logic [GATE_W-1:0] gate_lo, gate_hi;
   logic [COEF_W-1:0] coef_distance, coef_depth, coef_surface;

   logic [CNT_W-1:0]  frame_len;
   logic [AMP_W-1:0]  peak_amp;
   logic [IDX_W-1:0]  peak_idx;
   logic              peak_seen;
   logic [IDX_W-1:0]  zero_idx;
   logic              zero_seen;
   logic [IDX_W-1:0]  base_idx;
   logic              base_seen;
   logic              past_bound;

   int err_total = 0;
   int n_checked = 0;
   int n_base = 0;
   int n_long = 0;

   function automatic logic [OUT_W-1:0] scaled_index(input logic [IDX_W-1:0] idx,
                                                     input logic [COEF_W-1:0] coef);
      longint unsigned prod;
      prod = idx;
      prod = (prod * coef) >> FRAC_DROP;
      if (prod > SCALE_LIMIT) begin
         return {OUT_W{1'b1}};
      end
      return OUT_W'(prod);
   endfunction

   function automatic int field_differs(input string field, input longint unsigned want,
                                        input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic clear_frame();
      frame_len = '0;
      peak_amp = '0;
      peak_idx = '0;
      peak_seen = 1'b0;
      zero_idx = '0;
      zero_seen = 1'b0;
      base_idx = '0;
      base_seen = 1'b0;
      past_bound = 1'b0;
   endtask

   task automatic load_defaults();
      gate_lo = '0;
      gate_hi = {GATE_W{1'b1}};
      coef_distance = COEF_W'(65536);
      coef_depth = COEF_W'(65536);
      coef_surface = '0;
   endtask

   task automatic apply_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [COEF_W-1:0] value);
      case (idx)
         CSR_GATE_START: gate_lo = value[GATE_W-1:0];
         CSR_GATE_END:   gate_hi = value[GATE_W-1:0];
         CSR_DISTANCE:   coef_distance = value;
         CSR_DEPTH:      coef_depth = value;
         CSR_SURFACE:    coef_surface = value;
         default: ;
      endcase
   endtask

   task automatic track_sample(input logic [AMP_W-1:0] amp, input logic last);
      logic [IDX_W-1:0] idx;
      bit               in_gate;
      bit               has_base;
      frame_result_type res;
      if (int'(frame_len) >= MAX_SAMPLES) begin
         past_bound = 1'b1;
      end else begin
         idx = IDX_W'(frame_len);
         in_gate = (int'(frame_len) >= int'(gate_lo)) && (int'(frame_len) <= int'(gate_hi));
         if (in_gate && amp > peak_amp) begin
            peak_amp = amp;
            peak_idx = idx;
            peak_seen = 1'b1;
            base_idx = zero_idx;
            base_seen = zero_seen;
         end
         if (amp == '0) begin
            zero_idx = idx;
            zero_seen = 1'b1;
         end
         frame_len = frame_len + 1'b1;
      end
      if (last) begin
         has_base = peak_seen && base_seen;
         res.peak_height = peak_seen ? peak_amp : '0;
         res.peak_found = peak_seen;
         res.peak_position = peak_seen ? POS_W'(peak_idx) : '0;
         res.base_found = has_base;
         res.base_position = has_base ? POS_W'(base_idx) : '0;
         res.base_distance = has_base ? scaled_index(base_idx, coef_distance) : '0;
         res.depth = has_base ? scaled_index(base_idx, coef_depth) : '0;
         res.surface_distance = has_base ? scaled_index(base_idx, coef_surface) : '0;
         res.frame_overflow = past_bound;
         expected_frames.push_back(res);
         clear_frame();
      end
   endtask

   task automatic compare_result();
      frame_result_type want;
      int               bad;
      if (expected_frames.size() == 0) begin
         $error("result transfer with no frame pending");
         err_total++;
         return;
      end
      want = expected_frames.pop_front();
      bad = 0;
      bad += field_differs("peak_height", want.peak_height, rsp_peak_height);
      bad += field_differs("peak_found", want.peak_found, rsp_peak_found);
      bad += field_differs("peak_position", want.peak_position, rsp_peak_position);
      bad += field_differs("base_found", want.base_found, rsp_base_found);
      bad += field_differs("base_position", want.base_position, rsp_base_position);
      bad += field_differs("base_distance", want.base_distance, rsp_base_distance);
      bad += field_differs("depth", want.depth, rsp_depth);
      bad += field_differs("surface_distance", want.surface_distance, rsp_surface_distance);
      bad += field_differs("frame_overflow", want.frame_overflow, rsp_frame_overflow);
      err_total += bad;
      n_checked++;
      if (want.base_found) n_base++;
      if (want.frame_overflow) n_long++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_defaults();
         clear_frame();
         expected_frames.delete();
      end else begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (req_valid && !req_stall) track_sample(req_amplitude, req_last_sample);
         if (rsp_valid && !rsp_stall) compare_result();
      end
      failures <= err_total;
      outstanding <= expected_frames.size();
      frames_checked <= n_checked;
      base_frames <= n_base;
      long_frames <= n_long;
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the gate peak and base detector testbench: clock, reset, frame stimulus and verdict.
module testbench;
   import gpbd_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_ITEMS   = 70;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [AMP_W-1:0]     req_amplitude = '0;
   logic                 req_last_sample = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [AMP_W-1:0]     rsp_peak_height;
   logic                 rsp_peak_found;
   logic [POS_W-1:0]     rsp_peak_position;
   logic                 rsp_base_found;
   logic [POS_W-1:0]     rsp_base_position;
   logic [OUT_W-1:0]     rsp_base_distance;
   logic [OUT_W-1:0]     rsp_depth;
   logic [OUT_W-1:0]     rsp_surface_distance;
   logic                 rsp_frame_overflow;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GATE_START;
   logic [COEF_W-1:0]    csr_data = '0;

   int failures, outstanding, frames_checked, base_frames, long_frames;

   int  cycle_count = 0;
   int  samples_sent = 0;
   int  hold_requests = 0;
   int  hold_served = 0;
   bit  quiet = 1'b0;
   int  stall_left = 0;
   int  run_left = 0;
   int  phase_kind;
   int  phase_start;
   logic [AMP_W-1:0] directed_amps[$];

   gate_peak_base_detector_unit u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_amplitude, .req_last_sample,
      .rsp_valid, .rsp_stall, .rsp_peak_height, .rsp_peak_found, .rsp_peak_position,
      .rsp_base_found, .rsp_base_position, .rsp_base_distance, .rsp_depth,
      .rsp_surface_distance, .rsp_frame_overflow,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   gate_result_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_amplitude, .req_last_sample,
      .rsp_valid, .rsp_stall, .rsp_peak_height, .rsp_peak_found, .rsp_peak_position,
      .rsp_base_found, .rsp_base_position, .rsp_base_distance, .rsp_depth,
      .rsp_surface_distance, .rsp_frame_overflow,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .failures, .outstanding, .frames_checked, .base_frames, .long_frames
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // result side: random stall bursts, one long hold on request, none when quiet
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         run_left = 0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         stall_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (run_left > 0) begin
         run_left--;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_stall <= 1'b1;
      end else begin
         run_left = $urandom_range(1, 30);
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [AMP_W-1:0] pick_amp(input logic [AMP_W-1:0] tie);
      case ($urandom_range(0, 9))
         0, 1, 2: return '0;
         3:       return {AMP_W{1'b1}};
         4:       return tie;
         5:       return AMP_W'(1);
         default: return AMP_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int pick_len(input bit short_frames);
      if (short_frames) return $urandom_range(1, 4);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: return $urandom_range(1, 16);
         7, 8:                return $urandom_range(17, 48);
         default:             return $urandom_range(49, 120);
      endcase
   endfunction

   function automatic int unsigned pick_coef();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 24'hFFFFFF;
         default: return $urandom_range(0, 24'hFFFFFF);
      endcase
   endfunction

   task automatic send_sample(input logic [AMP_W-1:0] amp, input logic last);
      req_valid <= 1'b1;
      req_amplitude <= amp;
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_frame(input int len);
      logic [AMP_W-1:0] tie;
      int               i;
      tie = AMP_W'($urandom_range(1, 255));
      for (i = 0; i < len; i++) begin
         if (!quiet && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 14));
         send_sample(pick_amp(tie), i == len - 1);
      end
   endtask

   task automatic play_directed();
      int i;
      for (i = 0; i < directed_amps.size(); i++) begin
         send_sample(directed_amps[i], i == directed_amps.size() - 1);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= COEF_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_settings(input int kind);
      int unsigned lo, hi;
      case (kind)
         0: begin lo = 0; hi = 4095; end
         1: begin lo = 0; hi = 4095; end
         2: begin lo = $urandom_range(0, 15); hi = $urandom_range(lo, 40); end
         3: begin lo = $urandom_range(0, 10); hi = $urandom_range(10, 30); end
         4: begin lo = $urandom_range(10, 40); hi = $urandom_range(0, lo - 1); end
         5: begin lo = $urandom_range(0, 12); hi = lo; end
         6: begin lo = $urandom_range(3800, 4095); hi = 4095; end
         default: begin lo = 0; hi = $urandom_range(0, 4095); end
      endcase
      write_register(CSR_GATE_START, lo);
      write_register(CSR_GATE_END, hi);
      case (kind)
         0: begin
            write_register(CSR_DISTANCE, 65536);
            write_register(CSR_DEPTH, 65536);
            write_register(CSR_SURFACE, 0);
         end
         1: begin
            write_register(CSR_DISTANCE, 24'hFFFFFF);
            write_register(CSR_DEPTH, 24'hFFFFFF);
            write_register(CSR_SURFACE, 24'hFFFFFF);
         end
         3: begin
            write_register(CSR_DISTANCE, 0);
            write_register(CSR_DEPTH, 0);
            write_register(CSR_SURFACE, 0);
         end
         default: begin
            write_register(CSR_DISTANCE, pick_coef());
            write_register(CSR_DEPTH, pick_coef());
            write_register(CSR_SURFACE, pick_coef());
         end
      endcase
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: lone zero, lone maximum, equal peaks, base ahead of peak
      directed_amps = '{0};
      play_directed();
      directed_amps = '{255};
      play_directed();
      directed_amps = '{0, 7, 7, 0, 255, 255};
      play_directed();
      directed_amps = '{3, 0, 0, 9, 0, 9, 1};
      play_directed();
      directed_amps = '{1, 0, 0};
      play_directed();

      // reversed gate with maximum coefficients
      drain_results();
      write_register(CSR_GATE_START, 4095);
      write_register(CSR_GATE_END, 0);
      write_register(CSR_DISTANCE, 24'hFFFFFF);
      write_register(CSR_DEPTH, 24'hFFFFFF);
      write_register(CSR_SURFACE, 24'hFFFFFF);
      csr_valid <= 1'b0;
      directed_amps = '{0, 200, 255};
      play_directed();

      // one-sample gate
      drain_results();
      write_register(CSR_GATE_START, 2);
      write_register(CSR_GATE_END, 2);
      csr_valid <= 1'b0;
      directed_amps = '{50, 0, 9, 9};
      play_directed();

      for (phase_kind = 0; phase_kind < 8; phase_kind++) begin
         drain_results();
         write_settings(phase_kind);
         if (phase_kind == 3) hold_requests <= hold_requests + 1;
         if (phase_kind == 7) quiet <= 1'b1;
         if (phase_kind == 6) begin
            send_frame(MAX_SAMPLES);
            send_frame(MAX_SAMPLES + $urandom_range(1, 24));
            repeat (4) send_frame(pick_len(1'b0));
         end else begin
            phase_start = samples_sent;
            while (samples_sent - phase_start < PHASE_ITEMS) begin
               send_frame(pick_len(phase_kind == 3));
            end
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d samples in %0d frames over eleven register settings",
               samples_sent, frames_checked);
      $display("%0d frames had a base point, %0d ran past the sample bound",
               base_frames, long_frames);
      if (failures == 0 && outstanding == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
